[hdl/sapr_pkg.sv]
// Shared types, widths and constants of the sphere angle to ring pixel block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sapr_pkg;

  // Field widths.
  localparam int unsigned ANGLE_BITS = 24;
  localparam int unsigned TH_W       = ANGLE_BITS + 1;
  localparam int unsigned AZ_W       = ANGLE_BITS + 3;
  localparam int unsigned TT_W       = ANGLE_BITS + 1;
  localparam int unsigned RES_W      = 14;
  localparam int unsigned PIX_W      = 30;

  // Resolution register.
  localparam logic [RES_W-1:0] RES_RESET = 14'd64;
  localparam logic [RES_W-1:0] RES_MAX   = 14'd8192;

  // Fixed-point formats of the cosine series and the square root.
  localparam int unsigned X_W    = 30;
  localparam int unsigned R_W    = 31;
  localparam int unsigned Z_W    = ANGLE_BITS + 2;
  localparam int unsigned W_W    = 27;
  localparam int unsigned ROOT_W = 24;
  localparam int unsigned V_W    = 2 * ROOT_W;

  localparam logic [31:0]    PI_Q30 = 32'hC90F_DAA2;
  localparam logic [R_W-1:0] ONE30  = 31'h4000_0000;

  // Horner divisors. The sine uses one step fewer, so its first entry is unused.
  localparam int unsigned HORNER_STEPS = 6;
  localparam int unsigned COS_DIV [HORNER_STEPS] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [HORNER_STEPS] = '{2, 110, 72, 42, 20, 6};

  // Sideband that travels with each beat down the whole pipe.
  typedef struct packed {
    logic [RES_W-1:0] n;
    logic [TT_W-1:0]  tt;
    logic             neg;
    logic             use_sin;
    logic [X_W-1:0]   x;
    logic [Z_W-1:0]   z;
    logic             belt;
    logic [W_W-1:0]   wp;
    logic [W_W-1:0]   wm;
  } side_t;

  // Horner series operands.
  typedef struct packed {
    logic [X_W-1:0] x2;
    logic [R_W-1:0] r;
  } ser_t;

  // Square root partial result: root so far and what is left of the radicand.
  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [V_W-1:0]    diff;
  } sq_t;

endpackage

`default_nettype wire

[hdl/sapr_if.sv]
// Valid/ready channel interfaces for the input directions and the pixel results.
// Depends on sapr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sapr_in_if import sapr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [TH_W-1:0]        polar_angle;
  logic signed [AZ_W-1:0] azimuth;

  modport source (output valid, output polar_angle, output azimuth, input ready);
  modport sink   (input valid, input polar_angle, input azimuth, output ready);
endinterface

interface sapr_out_if import sapr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_index;

  modport source (output valid, output pixel_index, input ready);
  modport sink   (input valid, input pixel_index, output ready);
endinterface

`default_nettype wire

[hdl/sphere_angle_to_ring_pixel_top.sv]
// Direction to ring-ordered equal-area pixel: one beat in and one beat out per cycle unless stalled.
// Depends on sapr_pkg, sapr_if, sapr_horner_cell, sapr_sqrt_cell and sapr_pix_tail.
//
// The block maps a direction (polar angle with 2^24 equal to pi, azimuth with
// 2^25 equal to 2pi) to its pixel number in the ring-ordered equal-area sky
// pixelization of resolution n, taken from the cfg register (0 acts as 1,
// values above 8192 act as 8192). It is a fully pipelined row of cells: three
// front stages fold the angle and square it, six Horner cells of three stages
// each evaluate the cosine or sine series, two stages form z and the belt
// terms, 24 square root cells produce one root bit each, and a five-stage tail
// builds the pixel. A new beat is taken in every cycle while the row does not
// stall; a result passes through the whole cell row, mostly the 18 Horner
// stages and the 24 root cells. Stalls on the output collapse bubbles
// stage by stage, so the input keeps taking beats until the row is full.
// The resolution register may be written only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module sphere_angle_to_ring_pixel_top import sapr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  sapr_in_if.sink          in_ch,
  sapr_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_wdata
);

  localparam logic [TH_W-1:0] TH_PI      = TH_W'(1) << ANGLE_BITS;
  localparam logic [23:0]     TH_HALF    = 24'h80_0000;
  localparam logic [23:0]     TH_QUARTER = 24'h40_0000;
  localparam logic [24:0]     ZONE       = 25'h100_0000;
  localparam logic signed [Z_W-1:0] Z_ONE = 26'sd16777216;
  localparam int unsigned     SQ_CELLS   = ROOT_W;

  logic [RES_W-1:0] resolution_r;

  // Front stages.
  logic f0_v_r, f1_v_r, f2_v_r, f3_v_r, f4_v_r;
  logic f0_rdy, f1_rdy, f2_rdy, f3_rdy, f4_rdy;
  side_t f0_side_r, f1_side_r, f2_side_r, f3_side_r, f4_side_r;
  logic [22:0] f0_u_r;
  ser_t f2_ser_r;
  logic [R_W-1:0] f3_r_r;
  sq_t f4_sq_r;

  logic [RES_W-1:0] n_nxt;
  logic [TH_W-1:0]  th_sat;
  logic [23:0]      th_fold;
  logic [22:0]      u_nxt;
  side_t            side0_nxt;
  logic [54:0]      x_prod;
  logic [X_W-1:0]   x_nxt;
  side_t            side1_nxt;
  logic [60:0]      x2_prod;
  logic [60:0]      sin_prod;
  logic [R_W-1:0]   r_fin;
  logic [31:0]      c_rnd;
  logic [24:0]      c_sat;
  logic [Z_W-1:0]   z_nxt;
  logic [26:0]      c3;
  logic [27:0]      z3;
  logic [27:0]      wp_nxt, wm_nxt;
  logic [26:0]      s_nxt;
  side_t            side4_nxt;

  // Cell rows.
  logic  hr_v   [HORNER_STEPS+1];
  logic  hr_rdy [HORNER_STEPS+1];
  side_t hr_side[HORNER_STEPS+1];
  ser_t  hr_ser [HORNER_STEPS+1];

  logic  sq_v   [SQ_CELLS+1];
  logic  sq_rdy [SQ_CELLS+1];
  side_t sq_side[SQ_CELLS+1];
  sq_t   sq_dat [SQ_CELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r <= RES_RESET;
    end else if (cfg_we) begin
      resolution_r <= cfg_wdata;
    end
  end

  // Stage 0: clamp n and the polar angle, fold the angle into [0, pi/4].
  always_comb begin
    if (resolution_r == '0) begin
      n_nxt = RES_W'(1);
    end else if (resolution_r > RES_MAX) begin
      n_nxt = RES_MAX;
    end else begin
      n_nxt = resolution_r;
    end
    th_sat    = (in_ch.polar_angle > TH_PI) ? TH_PI : in_ch.polar_angle;
    side0_nxt = '0;
    side0_nxt.n  = n_nxt;
    side0_nxt.tt = in_ch.azimuth[TT_W-1:0];
    if (th_sat > TH_W'(TH_HALF)) begin
      th_fold       = 24'(TH_PI - th_sat);
      side0_nxt.neg = 1'b1;
    end else begin
      th_fold       = th_sat[23:0];
    end
    if (th_fold > TH_QUARTER) begin
      u_nxt             = 23'(TH_HALF - th_fold);
      side0_nxt.use_sin = 1'b1;
    end else begin
      u_nxt             = th_fold[22:0];
    end
  end

  // Stage 1: angle to radians in Q30, rounded half up.
  assign x_prod = 55'(f0_u_r) * 55'(PI_Q30) + 55'(24'h80_0000);
  assign x_nxt  = x_prod[53:24];

  always_comb begin
    side1_nxt   = f0_side_r;
    side1_nxt.x = x_nxt;
  end

  // Stage 2: the square of x, rounded half up.
  assign x2_prod = 61'(f1_side_r.x) * 61'(f1_side_r.x) + 61'(32'h2000_0000);

  // Stage 3: the sine branch multiplies the series by x.
  assign sin_prod = 61'(hr_side[HORNER_STEPS].x) * 61'(hr_ser[HORNER_STEPS].r);
  assign r_fin    = hr_side[HORNER_STEPS].use_sin ? sin_prod[60:30] : hr_ser[HORNER_STEPS].r;

  // Stage 4: z in Q24, the belt test, edge-line weights and the cap radicand.
  always_comb begin
    c_rnd  = (32'(f3_r_r) + 32'd32) >> 6;
    c_sat  = (c_rnd > 32'(ZONE)) ? ZONE : c_rnd[24:0];
    z_nxt  = f3_side_r.neg ? Z_W'(-$signed({1'b0, c_sat})) : Z_W'(c_sat);
    c3     = 27'(c_sat) * 27'd3;
    z3     = 28'($signed(z_nxt)) * 28'sd3;
    wp_nxt = 28'h200_0000 - z3;
    wm_nxt = 28'h200_0000 + z3;
    s_nxt  = 27'(ZONE - c_sat) * 27'd3;
    side4_nxt      = f3_side_r;
    side4_nxt.z    = z_nxt;
    side4_nxt.belt = (c3 <= 27'h200_0000);
    side4_nxt.wp   = wp_nxt[W_W-1:0];
    side4_nxt.wm   = wm_nxt[W_W-1:0];
  end

  assign f4_rdy = !f4_v_r | sq_rdy[0];
  assign f3_rdy = !f3_v_r | f4_rdy;
  assign hr_rdy[HORNER_STEPS] = f3_rdy;
  assign f2_rdy = !f2_v_r | hr_rdy[0];
  assign f1_rdy = !f1_v_r | f2_rdy;
  assign f0_rdy = !f0_v_r | f1_rdy;
  assign in_ch.ready = f0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      f4_v_r <= 1'b0;
    end else begin
      if (f0_rdy) f0_v_r <= in_ch.valid;
      if (f1_rdy) f1_v_r <= f0_v_r;
      if (f2_rdy) f2_v_r <= f1_v_r;
      if (f3_rdy) f3_v_r <= hr_v[HORNER_STEPS];
      if (f4_rdy) f4_v_r <= f3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f0_rdy) begin
      f0_side_r <= side0_nxt;
      f0_u_r    <= u_nxt;
    end
    if (f1_rdy) begin
      f1_side_r <= side1_nxt;
    end
    if (f2_rdy) begin
      f2_side_r   <= f1_side_r;
      f2_ser_r.x2 <= x2_prod[59:30];
      f2_ser_r.r  <= ONE30;
    end
    if (f3_rdy) begin
      f3_side_r <= hr_side[HORNER_STEPS];
      f3_r_r    <= r_fin;
    end
    if (f4_rdy) begin
      f4_side_r    <= side4_nxt;
      f4_sq_r.root <= '0;
      f4_sq_r.diff <= {s_nxt[ROOT_W-1:0], {ROOT_W{1'b0}}};
    end
  end

  assign hr_v[0]    = f2_v_r;
  assign hr_side[0] = f2_side_r;
  assign hr_ser[0]  = f2_ser_r;

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    sapr_horner_cell #(
      .K (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (hr_v[k]),
      .in_ready  (hr_rdy[k]),
      .in_side   (hr_side[k]),
      .in_ser    (hr_ser[k]),
      .out_valid (hr_v[k+1]),
      .out_ready (hr_rdy[k+1]),
      .out_side  (hr_side[k+1]),
      .out_ser   (hr_ser[k+1])
    );
  end

  assign sq_v[0]    = f4_v_r;
  assign sq_side[0] = f4_side_r;
  assign sq_dat[0]  = f4_sq_r;

  // Cell j settles root bit ROOT_W-1-j.
  for (genvar j = 0; j < SQ_CELLS; j++) begin : g_sqrt
    sapr_sqrt_cell #(
      .BIT (SQ_CELLS - 1 - j)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[j]),
      .in_ready  (sq_rdy[j]),
      .in_side   (sq_side[j]),
      .in_sq     (sq_dat[j]),
      .out_valid (sq_v[j+1]),
      .out_ready (sq_rdy[j+1]),
      .out_side  (sq_side[j+1]),
      .out_sq    (sq_dat[j+1])
    );
  end

  sapr_pix_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_v[SQ_CELLS]),
    .in_ready  (sq_rdy[SQ_CELLS]),
    .in_side   (sq_side[SQ_CELLS]),
    .in_root   (sq_dat[SQ_CELLS].root),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pix   (out_ch.pixel_index)
  );

  // No result beat may be offered in the cycle after reset.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result beat offered right after reset");

  // The series value never exceeds one in Q30 at the end of the Horner row.
  a_series_range: assert property (@(posedge clk) disable iff (!rst_n)
    hr_v[HORNER_STEPS] |-> hr_ser[HORNER_STEPS].r <= ONE30)
    else $error("series value above one");

  // z stays within [-1, 1] after rounding and clamping.
  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    f4_v_r |-> ($signed(f4_side_r.z) <= Z_ONE) && ($signed(f4_side_r.z) >= -Z_ONE))
    else $error("z out of range");

  // The root is the floor: what is left is at most twice the root.
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[SQ_CELLS] |->
      sq_dat[SQ_CELLS].diff <= {{(V_W-ROOT_W-1){1'b0}}, sq_dat[SQ_CELLS].root, 1'b0})
    else $error("square root remainder too large");

endmodule

`default_nettype wire

[hdl/sapr_horner_cell.sv]
// One Horner step of the cosine/sine series: multiply, reciprocal divide, correct.
// Depends on sapr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sapr_horner_cell import sapr_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  side_t in_side,
  input  ser_t  in_ser,
  output logic  out_valid,
  input  logic  out_ready,
  output side_t out_side,
  output ser_t  out_ser
);

  localparam logic [7:0]  COS_D = 8'(COS_DIV[K]);
  localparam logic [7:0]  SIN_D = 8'(SIN_DIV[K]);
  localparam logic [31:0] COS_M = 32'(64'h1_0000_0000 / 64'(COS_DIV[K]));
  localparam logic [31:0] SIN_M = 32'(64'h1_0000_0000 / 64'(SIN_DIV[K]));
  localparam bit          SIN_SKIP = (K == 0);

  logic [2:0] v_r;
  logic [2:0] rdy;

  side_t          side1_r, side2_r, side3_r;
  ser_t           ser1_r, ser2_r, ser3_r;
  logic [X_W-1:0] pr1_r, pr2_r;
  logic [X_W-1:0] q0_r;

  logic [60:0]    prod1;
  logic [31:0]    recip;
  logic [61:0]    prod2;
  logic [7:0]     dv;
  logic [37:0]    qd;
  logic [37:0]    rem;
  logic [X_W-1:0] q;
  logic [R_W-1:0] r_nxt;

  assign rdy[2]   = !v_r[2] | out_ready;
  assign rdy[1]   = !v_r[1] | rdy[2];
  assign rdy[0]   = !v_r[0] | rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    prod1 = 61'(in_ser.x2) * 61'(in_ser.r);
    recip = side1_r.use_sin ? SIN_M : COS_M;
    prod2 = 62'(pr1_r) * 62'(recip);
    dv    = side2_r.use_sin ? SIN_D : COS_D;
    qd    = 38'(q0_r) * 38'(dv);
    rem   = 38'(pr2_r) - qd;
    // The reciprocal estimate is low by at most one.
    q     = q0_r + X_W'(rem >= 38'(dv));
    if (side2_r.use_sin && SIN_SKIP) begin
      r_nxt = ser2_r.r;
    end else begin
      r_nxt = ONE30 - R_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side1_r <= in_side;
      ser1_r  <= in_ser;
      pr1_r   <= prod1[59:30];
    end
    if (rdy[1]) begin
      side2_r <= side1_r;
      ser2_r  <= ser1_r;
      pr2_r   <= pr1_r;
      q0_r    <= prod2[61:32];
    end
    if (rdy[2]) begin
      side3_r   <= side2_r;
      ser3_r.x2 <= ser2_r.x2;
      ser3_r.r  <= r_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign out_side  = side3_r;
  assign out_ser   = ser3_r;

endmodule

`default_nettype wire

[hdl/sapr_sqrt_cell.sv]
// One bit of the digit-by-digit integer square root, one pipeline register.
// Depends on sapr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sapr_sqrt_cell import sapr_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  side_t in_side,
  input  sq_t   in_sq,
  output logic  out_valid,
  input  logic  out_ready,
  output side_t out_side,
  output sq_t   out_sq
);

  logic           v_r;
  side_t          side_r;
  sq_t            sq_r;
  logic [V_W-1:0] trial;
  sq_t            sq_nxt;

  assign in_ready = !v_r | out_ready;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  always_comb begin
    trial  = (V_W'(in_sq.root) << (BIT + 1)) + (V_W'(1) << (2 * BIT));
    sq_nxt = in_sq;
    if (in_sq.diff >= trial) begin
      sq_nxt.diff = in_sq.diff - trial;
      sq_nxt.root = in_sq.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      side_r <= in_side;
      sq_r   <= sq_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_side  = side_r;
  assign out_sq    = sq_r;

endmodule

`default_nettype wire

[hdl/sapr_pix_tail.sv]
// Five-stage tail that turns z, the azimuth and the cap root into the ring pixel.
// Depends on sapr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sapr_pix_tail import sapr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  side_t             in_side,
  input  logic [ROOT_W-1:0] in_root,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_pix
);

  logic [4:0] v_r;
  logic [4:0] rdy;

  // Stage 0: products with n.
  logic [RES_W-1:0] n0_r;
  logic [TT_W-1:0]  tt0_r;
  logic [Z_W-1:0]   z0_r;
  logic             belt0_r;
  logic [38:0]      a0_r;
  logic [40:0]      bp0_r, bm0_r;
  logic [37:0]      m0_r;

  // Stage 1: belt edge lines, cap partial products.
  logic [RES_W-1:0] n1_r;
  logic [TT_W-1:0]  tt1_r;
  logic [Z_W-1:0]   z1_r;
  logic             belt1_r;
  logic [16:0]      jpb1_r, jmb1_r;
  logic [36:0]      php1_r;
  logic [46:0]      plp1_r;
  logic [37:0]      phq1_r;
  logic [47:0]      plq1_r;

  // Stage 2: rings.
  logic [RES_W-1:0] n2_r;
  logic [TT_W-1:0]  tt2_r;
  logic             zpos2_r;
  logic             belt2_r;
  logic [19:0]      irb2_r;
  logic [18:0]      ipb2_r;
  logic [17:0]      irc2_r;

  // Stage 3: ring offsets.
  logic             zpos3_r;
  logic             belt3_r;
  logic [18:0]      ipb3_r;
  logic [31:0]      p1_3_r, p2_3_r;
  logic [42:0]      pip3_r;
  logic [31:0]      ring3_r;
  logic [27:0]      nn3_r;
  logic [17:0]      irc3_r;

  logic [PIX_W-1:0] pix_r;

  logic [26:0] cy_p, cy_m;
  logic [16:0] jpb_nxt, jmb_nxt;
  logic [19:0] irb_nxt, num;
  logic [18:0] ipb_nxt;
  logic [37:0] sum_p;
  logic [38:0] sum_q;
  logic [17:0] irc_nxt;
  logic        zpos_nxt;
  logic [18:0] ipb_adj;
  logic [15:0] four_n;
  logic [19:0] irb_m1;
  logic [31:0] irb_ext;
  logic [31:0] p2_nxt;
  logic [27:0] nn_nxt;
  logic [31:0] p1_nxt;
  logic [17:0] ir_adj;
  logic [31:0] ring_nxt;
  logic [20:0] ipc, ipc_adj;
  logic [19:0] four_ir;
  logic [31:0] npix, pix_b, pix_c, pix_sel;

  assign rdy[4]   = !v_r[4] | out_ready;
  assign rdy[3]   = !v_r[3] | rdy[4];
  assign rdy[2]   = !v_r[2] | rdy[3];
  assign rdy[1]   = !v_r[1] | rdy[2];
  assign rdy[0]   = !v_r[0] | rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    // floor(n*tt/2^23 + n*w/2^26) with the carry of the two fractions.
    cy_p    = 27'({a0_r[22:0], 3'b000}) + 27'(bp0_r[25:0]);
    cy_m    = 27'({a0_r[22:0], 3'b000}) + 27'(bm0_r[25:0]);
    jpb_nxt = 17'(a0_r[38:23]) + 17'(bp0_r[40:26]) + 17'(cy_p[26]);
    jmb_nxt = 17'(a0_r[38:23]) + 17'(bm0_r[40:26]) + 17'(cy_m[26]);

    irb_nxt = 20'(n1_r) + 20'd1 + 20'(jpb1_r) - 20'(jmb1_r);
    num     = 20'(jpb1_r) + 20'(jmb1_r) + 20'(!irb_nxt[0]) + 20'd1 - 20'(n1_r);
    ipb_nxt = num[19] ? 19'd1 : 19'(num[19:1]) + 19'd1;
    sum_p   = 38'(php1_r) + 38'(plp1_r[46:24]);
    sum_q   = 39'(phq1_r) + 39'(plq1_r[47:24]);
    irc_nxt = 18'(sum_p[37:23]) + 18'(sum_q[38:23]) + 18'd1;
    zpos_nxt = !z1_r[Z_W-1] && (z1_r != '0);

    four_n  = {n2_r, 2'b00};
    ipb_adj = (ipb2_r > 19'(four_n)) ? ipb2_r - 19'(four_n) : ipb2_r;
    irb_m1  = irb2_r - 20'd1;
    irb_ext = {{12{irb_m1[19]}}, irb_m1};
    p2_nxt  = (32'(n2_r) * irb_ext) << 2;
    nn_nxt  = 28'(n2_r) * 28'(n2_r);
    p1_nxt  = (32'(nn_nxt) - 32'(n2_r)) << 1;
    ir_adj  = zpos2_r ? irc2_r - 18'd1 : irc2_r + 18'd1;
    ring_nxt = 32'(irc2_r) * 32'(ir_adj);

    ipc     = 21'(pip3_r[42:23]) + 21'd1;
    four_ir = {irc3_r, 2'b00};
    ipc_adj = (ipc > 21'(four_ir)) ? ipc - 21'(four_ir) : ipc;
    npix    = (32'(nn3_r) << 3) + (32'(nn3_r) << 2);
    pix_b   = p1_3_r + p2_3_r + 32'(ipb3_r);
    if (zpos3_r) begin
      pix_c = (ring3_r << 1) + 32'(ipc_adj);
    end else begin
      pix_c = npix - (ring3_r << 1) + 32'(ipc_adj);
    end
    pix_sel = (belt3_r ? pix_b : pix_c) - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      n0_r    <= in_side.n;
      tt0_r   <= in_side.tt;
      z0_r    <= in_side.z;
      belt0_r <= in_side.belt;
      a0_r    <= 39'(in_side.n) * 39'(in_side.tt);
      bp0_r   <= 41'(in_side.n) * 41'(in_side.wp);
      bm0_r   <= 41'(in_side.n) * 41'(in_side.wm);
      m0_r    <= 38'(in_side.n) * 38'(in_root);
    end
    if (rdy[1]) begin
      n1_r    <= n0_r;
      tt1_r   <= tt0_r;
      z1_r    <= z0_r;
      belt1_r <= belt0_r;
      jpb1_r  <= jpb_nxt;
      jmb1_r  <= jmb_nxt;
      php1_r  <= 37'(m0_r[37:24]) * 37'(tt0_r[22:0]);
      plp1_r  <= 47'(m0_r[23:0]) * 47'(tt0_r[22:0]);
      phq1_r  <= 38'(m0_r[37:24]) * 38'(24'h80_0000 - 24'(tt0_r[22:0]));
      plq1_r  <= 48'(m0_r[23:0]) * 48'(24'h80_0000 - 24'(tt0_r[22:0]));
    end
    if (rdy[2]) begin
      n2_r    <= n1_r;
      tt2_r   <= tt1_r;
      zpos2_r <= zpos_nxt;
      belt2_r <= belt1_r;
      irb2_r  <= irb_nxt;
      ipb2_r  <= ipb_nxt;
      irc2_r  <= irc_nxt;
    end
    if (rdy[3]) begin
      zpos3_r <= zpos2_r;
      belt3_r <= belt2_r;
      ipb3_r  <= ipb_adj;
      p1_3_r  <= p1_nxt;
      p2_3_r  <= p2_nxt;
      pip3_r  <= 43'(tt2_r) * 43'(irc2_r);
      ring3_r <= ring_nxt;
      nn3_r   <= nn_nxt;
      irc3_r  <= irc2_r;
    end
    if (rdy[4]) begin
      pix_r <= pix_sel[PIX_W-1:0];
    end
  end

  assign out_valid = v_r[4];
  assign out_pix   = pix_r;

endmodule

`default_nettype wire
